>>> hw/rtl/heron_triangle_area_defines.svh
// Assertion macros used by the checker file.
`ifndef HERON_TRIANGLE_AREA_DEFINES_SVH
`define HERON_TRIANGLE_AREA_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define HTA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequence checked in the cycle after the antecedent.
`define HTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/hta_pkg.sv
package hta_pkg;
  localparam int SIDE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int AREA_W        = 24;
  localparam int HEIGHT_W      = 16;

  localparam logic [1:0] KIND_EQUI    = 2'd0;
  localparam logic [1:0] KIND_ISO     = 2'd1;
  localparam logic [1:0] KIND_SCALENE = 2'd2;
endpackage

>>> hw/rtl/hta_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module hta_div import hta_pkg::*; #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);
  localparam int RW = DEN_W + 1;

  logic [NUM_W-1:0] num_r [NUM_W+1];
  logic [RW-1:0]    rem_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];
  logic             vld_r [NUM_W+1];

  always_comb begin
    num_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
    vld_r[0] = in_vld;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_st
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {rem_r[i][RW-2:0], num_r[i][NUM_W-1]};
    assign ge    = trial >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i+1] <= ge ? trial - {1'b0, den_r[i]} : trial;
        num_r[i+1] <= {num_r[i][NUM_W-2:0], ge};
        den_r[i+1] <= den_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign out_vld = vld_r[NUM_W];
  assign out_quo = num_r[NUM_W];
  assign out_tag = tag_r[NUM_W];
endmodule

>>> hw/rtl/heron_triangle_area.sv
// Depth: 3 + RTW + 1 + NW + 1 register stages, where RTW = (4*SIDE_BITS - 2*FRAC_BITS + 5) / 2
// and NW = 25 + FRAC_BITS. At the default Q8.8 sides that is 64 stages. The depth comes from
// the one-bit-per-stage square root and divider pipelines.
// Throughput: one beat per cycle; a stall on a valid output freezes every stage.
// Reset: rst_n is synchronous, active low, and clears every stage valid bit.
module heron_triangle_area import hta_pkg::*; #(
  parameter int SIDE_BITS = SIDE_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SIDE_BITS-1:0] in_side_a,
  input  logic [SIDE_BITS-1:0] in_side_b,
  input  logic [SIDE_BITS-1:0] in_side_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_valid_triangle,
  output logic [1:0]           out_kind,
  output logic [SIDE_BITS-1:0] out_base_side,
  output logic [HEIGHT_W-1:0]  out_height,
  output logic [AREA_W-1:0]    out_area
);
  // The whole pipeline advances together. The output register holds a
  // finished beat while the stages behind it wait; a stalled valid output
  // back-pressures the input in the same cycle.
  localparam int SW  = SIDE_BITS + 2;          // perimeter width
  localparam int PW  = 4 * SW;                  // product width
  localparam int SH  = 2 * FRAC_BITS + 4;       // scaling shift
  localparam int VW  = (PW > SH) ? PW - SH : 1; // scaled radicand width
  localparam int RTW = (VW + 1) / 2;            // root width
  localparam int RDW = 2 * RTW;                 // padded radicand
  localparam int NW  = AREA_W + 1 + FRAC_BITS;  // dividend width
  localparam int TW  = 1 + 2 + SIDE_BITS + AREA_W;

  typedef struct packed {
    logic                 ok;
    logic [1:0]           kind;
    logic [SIDE_BITS-1:0] base;
  } meta_t;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: sums, triangle check, classification.
  logic          v1_r;
  meta_t         m1_r;
  logic [SW-1:0] p_r, x_r, y_r, z_r;
  logic [SW-1:0] a, b, c;
  meta_t         m1_nxt;

  assign a = SW'(in_side_a);
  assign b = SW'(in_side_b);
  assign c = SW'(in_side_c);

  always_comb begin
    m1_nxt.ok = (a != '0) && (b != '0) && (c != '0) &&
                (a < b + c) && (b < a + c) && (c < a + b);
    if (a == b && a == c) begin
      m1_nxt.kind = KIND_EQUI;
      m1_nxt.base = in_side_a;
    end else if (a == b || b == c || a == c) begin
      m1_nxt.kind = KIND_ISO;
      m1_nxt.base = (a == b) ? in_side_c : (b == c) ? in_side_a : in_side_b;
    end else begin
      m1_nxt.kind = KIND_SCALENE;
      m1_nxt.base = (a > b && a > c) ? in_side_a :
                    (b > a && b > c) ? in_side_b : in_side_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= m1_nxt;
      p_r  <= a + b + c;
      x_r  <= b + c - a;
      y_r  <= a + c - b;
      z_r  <= a + b - c;
    end
  end

  // Stages 2 and 3: two products, then their product.
  logic            v2_r, v3_r;
  meta_t           m2_r, m3_r;
  logic [2*SW-1:0] px_r, yz_r;
  logic [PW-1:0]   prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r   <= m1_r;
      px_r   <= p_r * x_r;
      yz_r   <= y_r * z_r;
      m3_r   <= m2_r;
      prod_r <= px_r * yz_r;
    end
  end

  // Square root pipeline: one root bit per stage.
  logic [VW-1:0]  rad;
  assign rad = (PW > SH) ? VW'(prod_r >> SH) : '0;

  logic [RDW-1:0] sq_x   [RTW+1];
  logic [RTW+1:0] sq_rem [RTW+1];
  logic [RTW-1:0] sq_rt  [RTW+1];
  meta_t          sq_m   [RTW+1];
  logic           sq_v   [RTW+1];

  always_comb begin
    sq_x[0]   = RDW'(rad);
    sq_rem[0] = '0;
    sq_rt[0]  = '0;
    sq_m[0]   = m3_r;
    sq_v[0]   = v3_r;
  end

  for (genvar i = 0; i < RTW; i++) begin : g_sq
    logic [RTW+1:0] trial, tst;
    logic           ge;
    assign trial = {sq_rem[i][RTW-1:0], sq_x[i][RDW-1 -: 2]};
    assign tst   = {sq_rt[i], 2'b01};
    assign ge    = trial >= tst;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v[i+1] <= sq_v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[i+1] <= ge ? trial - tst : trial;
        sq_rt[i+1]  <= {sq_rt[i][RTW-2:0], ge};
        sq_x[i+1]   <= {sq_x[i][RDW-3:0], 2'b00};
        sq_m[i+1]   <= sq_m[i];
      end
    end
  end

  // Saturate the area, then scale 2*area for the height division.
  logic              v4_r;
  meta_t             m4_r;
  logic [AREA_W-1:0] area_r, area_nxt;
  logic [RTW-1:0]    root;
  assign root = sq_rt[RTW];

  always_comb begin
    if (RTW > AREA_W) begin
      area_nxt = (root >= {{(RTW > AREA_W ? RTW - AREA_W : 1){1'b0}}, {AREA_W{1'b1}}})
                 ? {AREA_W{1'b1}} : AREA_W'(root);
    end else begin
      area_nxt = AREA_W'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= sq_v[RTW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_r   <= sq_m[RTW];
      area_r <= area_nxt;
    end
  end

  logic [NW-1:0] dnum;
  logic [TW-1:0] dtag_in, dtag_out;
  logic [NW-1:0] quo;
  logic          dv;
  assign dnum    = NW'({area_r, 1'b0}) << FRAC_BITS;
  assign dtag_in = {m4_r.ok, m4_r.kind, m4_r.base, area_r};

  hta_div #(.NUM_W(NW), .DEN_W(SIDE_BITS), .TAG_W(TW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (v4_r),
    .in_num  (dnum),
    .in_den  ((m4_r.base == '0) ? SIDE_BITS'(1) : m4_r.base),
    .in_tag  (dtag_in),
    .out_vld (dv),
    .out_quo (quo),
    .out_tag (dtag_out)
  );

  // Output register.
  meta_t             mo;
  logic [AREA_W-1:0] ao;
  assign {mo, ao} = dtag_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_valid_triangle <= mo.ok;
      out_kind           <= mo.ok ? mo.kind : KIND_EQUI;
      out_base_side      <= mo.ok ? mo.base : '0;
      out_area           <= mo.ok ? ao : '0;
      out_height         <= !mo.ok ? '0 :
                            (quo > NW'({HEIGHT_W{1'b1}})) ? {HEIGHT_W{1'b1}} :
                            HEIGHT_W'(quo);
    end
  end
endmodule

>>> hw/rtl/hta_checker.sv
`include "heron_triangle_area_defines.svh"
module hta_checker import hta_pkg::*; #(
  parameter int SIDE_BITS = SIDE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_valid_triangle,
  input logic [1:0]           out_kind,
  input logic [SIDE_BITS-1:0] out_base_side,
  input logic [HEIGHT_W-1:0]  out_height,
  input logic [AREA_W-1:0]    out_area
);
  `HTA_ASSERT_IMPL(a_stall_link, clk, rst_n, 1'b1, in_stall == (out_valid && out_stall))
  `HTA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_area))
  `HTA_ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid && !out_valid_triangle, out_area == '0 && out_height == '0 && out_base_side == '0 && out_kind == KIND_EQUI)
  `HTA_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_kind != 2'd3)
endmodule

bind heron_triangle_area hta_checker #(.SIDE_BITS(SIDE_BITS)) u_hta_checker (.*);
